// ===== hdl/bps_pkg.sv =====
// Shared types and constants for the board power sequencer.
// Depends on nothing; used by bps_step and board_power_sequencer.
package bps_pkg;

    localparam int unsigned TIME_W = 32;

    typedef enum logic [2:0] {
        MODE_OFF  = 3'd0,
        MODE_BOOT = 3'd1,
        MODE_CONN = 3'd2,
        MODE_SHUT = 3'd3,
        MODE_ERR  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        LED_OFF    = 3'd0,
        LED_BLINK  = 3'd1,
        LED_MANUAL = 3'd2,
        LED_ALT    = 3'd3,
        LED_FAST   = 3'd4
    } led_t;

    // Configuration register indexes
    localparam logic CFG_BOOT_TIMEOUT = 1'b0;
    localparam logic CFG_SHUTDOWN_WAIT = 1'b1;

    localparam logic [TIME_W-1:0] BOOT_TIMEOUT_RESET = 32'd60000;
    localparam logic [TIME_W-1:0] SHUTDOWN_WAIT_RESET = 32'd10000;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              button_clicked;
        logic              button_long;
        logic              link_up;
        logic              host_shutdown;
        logic              port1_wanted;
        logic              port2_wanted;
    } item_t;

    typedef struct packed {
        mode_t             mode;
        logic [TIME_W-1:0] stamp;
        logic              latch;
        logic              port1;
        logic              port2;
        led_t              led;
        logic              blank;
        logic              request;
    } state_t;

    typedef struct packed {
        logic wake;
        logic clear;
    } pulse_t;

    localparam state_t STATE_RESET = '{
        mode:    MODE_OFF,
        stamp:   '0,
        latch:   1'b0,
        port1:   1'b0,
        port2:   1'b0,
        led:     LED_OFF,
        blank:   1'b1,
        request: 1'b0
    };

endpackage

// ===== hdl/board_power_sequencer.sv =====
// Board power sequencer top level: input register, sequencer state, result register.
// Depends on bps_pkg and bps_step.
// A transaction accepted into the input register passes through bps_step and is registered in the result register.
// Throughput: one transaction per cycle while the result side takes them; m_ready low stalls both stages.
// Reset (aresetn low, synchronous): mode off, display blanked, timeouts back to 60000/10000 ms.
module board_power_sequencer (
    input  logic                       aclk,
    input  logic                       aresetn,

    // Configuration write port
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [bps_pkg::TIME_W-1:0] cfg_data,

    // Input channel: one transaction is one pass of the control loop
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [bps_pkg::TIME_W-1:0] s_now_ms,
    input  logic                       s_button_clicked,
    input  logic                       s_button_long,
    input  logic                       s_link_up,
    input  logic                       s_host_shutdown,
    input  logic                       s_port1_wanted,
    input  logic                       s_port2_wanted,

    // Result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_mode,
    output logic                       m_host_power,
    output logic                       m_port1_power,
    output logic                       m_port2_power,
    output logic [2:0]                 m_led_effect,
    output logic                       m_display_blanked,
    output logic                       m_display_wake,
    output logic                       m_shutdown_request,
    output logic                       m_clear_host_flag
);

    // Configuration registers
    logic [bps_pkg::TIME_W-1:0] boot_timeout_reg;
    logic [bps_pkg::TIME_W-1:0] shutdown_wait_reg;

    // Input stage
    logic            in_valid_reg;
    bps_pkg::item_t  in_item_reg;

    // Sequencer state and its next value from the step logic
    bps_pkg::state_t st_reg;
    bps_pkg::state_t st_next;
    bps_pkg::pulse_t pulse_next;

    // Result stage
    logic            out_valid_reg;
    bps_pkg::state_t out_state_reg;
    bps_pkg::pulse_t out_pulse_reg;

    logic s_fire;
    logic advance;

    // Advance the input stage whenever the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_timeout_reg  <= bps_pkg::BOOT_TIMEOUT_RESET;
            shutdown_wait_reg <= bps_pkg::SHUTDOWN_WAIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bps_pkg::CFG_BOOT_TIMEOUT:  boot_timeout_reg  <= cfg_data;
                bps_pkg::CFG_SHUTDOWN_WAIT: shutdown_wait_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the incoming transaction; payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.now_ms         <= s_now_ms;
            in_item_reg.button_clicked <= s_button_clicked;
            in_item_reg.button_long    <= s_button_long;
            in_item_reg.link_up        <= s_link_up;
            in_item_reg.host_shutdown  <= s_host_shutdown;
            in_item_reg.port1_wanted   <= s_port1_wanted;
            in_item_reg.port2_wanted   <= s_port2_wanted;
        end
    end

    bps_step u_step (
        .item             (in_item_reg),
        .st               (st_reg),
        .boot_timeout_ms  (boot_timeout_reg),
        .shutdown_wait_ms (shutdown_wait_reg),
        .nx               (st_next),
        .pulse            (pulse_next)
    );

    // Commit the sequencer state only when the pass moves into the result slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= bps_pkg::STATE_RESET;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Result slot: hold until taken, refill in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg <= st_next;
            out_pulse_reg <= pulse_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_mode             = out_state_reg.mode;
    assign m_host_power       = (out_state_reg.mode != bps_pkg::MODE_OFF);
    assign m_port1_power      = out_state_reg.port1;
    assign m_port2_power      = out_state_reg.port2;
    assign m_led_effect       = out_state_reg.led;
    assign m_display_blanked  = out_state_reg.blank;
    assign m_display_wake     = out_pulse_reg.wake;
    assign m_shutdown_request = out_state_reg.request;
    assign m_clear_host_flag  = out_pulse_reg.clear;

`ifndef SYNTHESIS
    // The sequencer state moves only with a pass
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("sequencer state changed without a pass");

    // Shutdown request is a level that lives only in shutting down
    a_request_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.request |-> (st_reg.mode == bps_pkg::MODE_SHUT))
        else $error("shutdown request outside shutting down");

    // Controller ports are powered only while connected
    a_ports_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.port1 || st_reg.port2) |-> (st_reg.mode == bps_pkg::MODE_CONN))
        else $error("controller port powered outside connected");

    // A wake pulse leaves the pass in error or, after a click, shutting down
    a_wake_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_display_wake) |->
            (m_clear_host_flag && ((m_mode == bps_pkg::MODE_ERR)
                || (m_mode == bps_pkg::MODE_SHUT))))
        else $error("display wake without error entry");
`endif

endmodule

// ===== hdl/bps_step.sv =====
// Next-state logic for one pass of the power sequencer control loop.
// Depends on bps_pkg for the item, state and pulse types.
module bps_step (
    input  bps_pkg::item_t                   item,
    input  bps_pkg::state_t                  st,
    input  logic [bps_pkg::TIME_W-1:0]       boot_timeout_ms,
    input  logic [bps_pkg::TIME_W-1:0]       shutdown_wait_ms,
    output bps_pkg::state_t                  nx,
    output bps_pkg::pulse_t                  pulse
);

    // Apply the output settings that belong to entering mode m.
    function automatic bps_pkg::state_t enter(
        input bps_pkg::state_t             s,
        input bps_pkg::mode_t              m,
        input logic [bps_pkg::TIME_W-1:0]  now,
        input logic                        p1,
        input logic                        p2
    );
        bps_pkg::state_t r;
        r = s;
        r.mode = m;
        case (m)
            bps_pkg::MODE_BOOT: begin
                r.port1 = 1'b0; r.port2 = 1'b0;
                r.led = bps_pkg::LED_BLINK; r.blank = 1'b1;
                r.stamp = now;
            end
            bps_pkg::MODE_CONN: begin
                r.led = bps_pkg::LED_MANUAL;
                r.port1 = p1; r.port2 = p2;
                r.blank = 1'b0;
            end
            bps_pkg::MODE_SHUT: begin
                r.port1 = 1'b0; r.port2 = 1'b0;
                r.led = bps_pkg::LED_ALT; r.blank = 1'b1;
                r.request = 1'b1;
                r.stamp = now;
            end
            bps_pkg::MODE_ERR: begin
                r.led = bps_pkg::LED_FAST; r.blank = 1'b0;
                r.request = 1'b0;
                r.port1 = 1'b0; r.port2 = 1'b0;
            end
            default: begin
                r.mode = bps_pkg::MODE_OFF;
                r.port1 = 1'b0; r.port2 = 1'b0;
                r.led = bps_pkg::LED_OFF; r.blank = 1'b1;
                r.request = 1'b0;
            end
        endcase
        return r;
    endfunction

    logic [bps_pkg::TIME_W-1:0] elapsed;
    logic                       boot_expired;
    logic                       shut_expired;
    logic                       click;

    // Wrapping difference against the stamp taken on entry
    assign elapsed      = item.now_ms - st.stamp;
    assign boot_expired = (elapsed >= boot_timeout_ms);
    assign shut_expired = (elapsed >= shutdown_wait_ms);

    always_comb begin
        nx    = st;
        pulse = '0;
        click = item.button_clicked;

        // Rising long press forces off and swallows this pass's click
        if (item.button_long && !st.latch) begin
            nx.latch    = 1'b1;
            click       = 1'b0;
            nx          = enter(nx, bps_pkg::MODE_OFF, item.now_ms,
                                item.port1_wanted, item.port2_wanted);
            pulse.clear = 1'b1;
        end else if (!item.button_long && st.latch) begin
            nx.latch = 1'b0;
        end

        case (nx.mode)
            bps_pkg::MODE_BOOT: begin
                if (item.link_up) begin
                    nx = enter(nx, bps_pkg::MODE_CONN, item.now_ms,
                               item.port1_wanted, item.port2_wanted);
                end
                if (boot_expired) begin
                    nx = enter(nx, bps_pkg::MODE_ERR, item.now_ms,
                               item.port1_wanted, item.port2_wanted);
                    pulse.wake  = 1'b1;
                    pulse.clear = 1'b1;
                end
            end
            bps_pkg::MODE_CONN: begin
                if (!item.link_up) begin
                    nx = enter(nx, bps_pkg::MODE_ERR, item.now_ms,
                               item.port1_wanted, item.port2_wanted);
                    pulse.wake  = 1'b1;
                    pulse.clear = 1'b1;
                end
                // Host flag is void once cleared earlier in the pass
                if ((item.host_shutdown && !pulse.clear) || click) begin
                    nx = enter(nx, bps_pkg::MODE_SHUT, item.now_ms,
                               item.port1_wanted, item.port2_wanted);
                    pulse.clear = 1'b1;
                end
            end
            bps_pkg::MODE_SHUT: begin
                if (shut_expired) begin
                    nx = enter(nx, bps_pkg::MODE_OFF, item.now_ms,
                               item.port1_wanted, item.port2_wanted);
                    pulse.clear = 1'b1;
                end
            end
            bps_pkg::MODE_ERR: begin
                if (click) begin
                    nx = enter(nx, bps_pkg::MODE_OFF, item.now_ms,
                               item.port1_wanted, item.port2_wanted);
                    pulse.clear = 1'b1;
                end
            end
            default: begin
                nx.mode = bps_pkg::MODE_OFF;
                if (click) begin
                    nx = enter(nx, bps_pkg::MODE_BOOT, item.now_ms,
                               item.port1_wanted, item.port2_wanted);
                end
            end
        endcase
    end

endmodule

// ===== sim/board_power_sequencer_tb.sv =====
// Self-checking testbench for the board power sequencer: a directed table, then random passes.
// Depends on bps_pkg and the board_power_sequencer RTL; reads nothing else.
`timescale 1ns / 100ps

module board_power_sequencer_tb;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic [2:0] mode;
        logic       host;
        logic       port1;
        logic       port2;
        logic [2:0] led;
        logic       blank;
        logic       wake;
        logic       request;
        logic       clear;
    } seq_out_t;

    // Flags are ordered as in item_t: click, long, link, host flag, port1, port2.
    typedef struct packed {
        logic [bps_pkg::TIME_W-1:0] now_ms;
        logic [5:0]                 flags;
        logic                       typed;
        seq_out_t                   want;
    } dir_row_t;

    // Receiver stall styles; a new style is drawn each time rx_cycle wraps.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_style_t;

    localparam int DIR_ROWS = 24;
    localparam int RX_HOLD_CYCLES = 200;

    localparam seq_out_t OUT_NONE = '0;
    localparam seq_out_t OUT_OFF_IDLE = '{mode: bps_pkg::MODE_OFF, host: 1'b0,
        port1: 1'b0, port2: 1'b0, led: bps_pkg::LED_OFF, blank: 1'b1, wake: 1'b0,
        request: 1'b0, clear: 1'b0};
    localparam seq_out_t OUT_OFF_CLEARED = '{mode: bps_pkg::MODE_OFF, host: 1'b0,
        port1: 1'b0, port2: 1'b0, led: bps_pkg::LED_OFF, blank: 1'b1, wake: 1'b0,
        request: 1'b0, clear: 1'b1};
    localparam seq_out_t OUT_ERR_ENTRY = '{mode: bps_pkg::MODE_ERR, host: 1'b1,
        port1: 1'b0, port2: 1'b0, led: bps_pkg::LED_FAST, blank: 1'b0, wake: 1'b1,
        request: 1'b0, clear: 1'b1};

    // ---------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic                       cfg_index = bps_pkg::CFG_BOOT_TIMEOUT;
    logic [bps_pkg::TIME_W-1:0] cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [bps_pkg::TIME_W-1:0] s_now_ms = '0;
    logic                       s_button_clicked = 1'b0;
    logic                       s_button_long = 1'b0;
    logic                       s_link_up = 1'b0;
    logic                       s_host_shutdown = 1'b0;
    logic                       s_port1_wanted = 1'b0;
    logic                       s_port2_wanted = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [2:0]                 m_mode;
    logic                       m_host_power;
    logic                       m_port1_power;
    logic                       m_port2_power;
    logic [2:0]                 m_led_effect;
    logic                       m_display_blanked;
    logic                       m_display_wake;
    logic                       m_shutdown_request;
    logic                       m_clear_host_flag;

    board_power_sequencer dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_now_ms           (s_now_ms),
        .s_button_clicked   (s_button_clicked),
        .s_button_long      (s_button_long),
        .s_link_up          (s_link_up),
        .s_host_shutdown    (s_host_shutdown),
        .s_port1_wanted     (s_port1_wanted),
        .s_port2_wanted     (s_port2_wanted),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_mode             (m_mode),
        .m_host_power       (m_host_power),
        .m_port1_power      (m_port1_power),
        .m_port2_power      (m_port2_power),
        .m_led_effect       (m_led_effect),
        .m_display_blanked  (m_display_blanked),
        .m_display_wake     (m_display_wake),
        .m_shutdown_request (m_shutdown_request),
        .m_clear_host_flag  (m_clear_host_flag)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Sequencer predictor: its own copy of the state and the timeouts
    // ---------------------------------------------------------------
    bps_pkg::mode_t             seq_mode = bps_pkg::MODE_OFF;
    logic [bps_pkg::TIME_W-1:0] seq_stamp = '0;
    logic                       seq_latch = 1'b0;
    logic                       seq_port1 = 1'b0;
    logic                       seq_port2 = 1'b0;
    bps_pkg::led_t              seq_led = bps_pkg::LED_OFF;
    logic                       seq_blank = 1'b1;
    logic                       seq_request = 1'b0;
    logic                       pend_wake;
    logic                       pend_clear;
    logic [bps_pkg::TIME_W-1:0] boot_limit = bps_pkg::BOOT_TIMEOUT_RESET;
    logic [bps_pkg::TIME_W-1:0] shut_limit = bps_pkg::SHUTDOWN_WAIT_RESET;

    // Apply the settings that go with entering mode m; pulses accumulate over the pass.
    function automatic void enter_mode(input bps_pkg::mode_t m, input bps_pkg::item_t it);
        seq_mode = m;
        case (m)
            bps_pkg::MODE_BOOT: begin
                seq_port1 = 1'b0;
                seq_port2 = 1'b0;
                seq_led   = bps_pkg::LED_BLINK;
                seq_blank = 1'b1;
                seq_stamp = it.now_ms;
            end
            bps_pkg::MODE_CONN: begin
                seq_led   = bps_pkg::LED_MANUAL;
                seq_port1 = it.port1_wanted;
                seq_port2 = it.port2_wanted;
                seq_blank = 1'b0;
            end
            bps_pkg::MODE_SHUT: begin
                seq_port1   = 1'b0;
                seq_port2   = 1'b0;
                seq_led     = bps_pkg::LED_ALT;
                seq_blank   = 1'b1;
                pend_clear  = 1'b1;
                seq_request = 1'b1;
                seq_stamp   = it.now_ms;
            end
            bps_pkg::MODE_ERR: begin
                seq_led     = bps_pkg::LED_FAST;
                seq_blank   = 1'b0;
                pend_wake   = 1'b1;
                pend_clear  = 1'b1;
                seq_request = 1'b0;
                seq_port1   = 1'b0;
                seq_port2   = 1'b0;
            end
            default: begin
                seq_mode    = bps_pkg::MODE_OFF;
                seq_port1   = 1'b0;
                seq_port2   = 1'b0;
                seq_led     = bps_pkg::LED_OFF;
                seq_blank   = 1'b1;
                pend_clear  = 1'b1;
                seq_request = 1'b0;
            end
        endcase
    endfunction

    // One pass of the control loop; later entries in the pass override earlier ones.
    function automatic seq_out_t sequence_pass(input bps_pkg::item_t it);
        logic                       click;
        logic [bps_pkg::TIME_W-1:0] elapsed;
        seq_out_t                   o;
        click      = it.button_clicked;
        elapsed    = it.now_ms - seq_stamp;
        pend_wake  = 1'b0;
        pend_clear = 1'b0;

        // A rising long press forces off and swallows the click of this pass.
        if (it.button_long && !seq_latch) begin
            seq_latch = 1'b1;
            click     = 1'b0;
            enter_mode(bps_pkg::MODE_OFF, it);
        end else if (!it.button_long && seq_latch) begin
            seq_latch = 1'b0;
        end

        case (seq_mode)
            bps_pkg::MODE_BOOT: begin
                if (it.link_up) enter_mode(bps_pkg::MODE_CONN, it);
                // The boot stamp survives the connected entry above.
                if (elapsed >= boot_limit) enter_mode(bps_pkg::MODE_ERR, it);
            end
            bps_pkg::MODE_CONN: begin
                if (!it.link_up) enter_mode(bps_pkg::MODE_ERR, it);
                // Once the host flag has been cleared this pass it reads as low.
                if (it.host_shutdown && !pend_clear) enter_mode(bps_pkg::MODE_SHUT, it);
                if (click) enter_mode(bps_pkg::MODE_SHUT, it);
            end
            bps_pkg::MODE_SHUT: begin
                if (elapsed >= shut_limit) enter_mode(bps_pkg::MODE_OFF, it);
            end
            bps_pkg::MODE_ERR: begin
                if (click) enter_mode(bps_pkg::MODE_OFF, it);
            end
            default: begin
                seq_mode = bps_pkg::MODE_OFF;
                if (click) enter_mode(bps_pkg::MODE_BOOT, it);
            end
        endcase

        o.mode    = seq_mode;
        o.host    = (seq_mode != bps_pkg::MODE_OFF);
        o.port1   = seq_port1;
        o.port2   = seq_port2;
        o.led     = seq_led;
        o.blank   = seq_blank;
        o.wake    = pend_wake;
        o.request = seq_request;
        o.clear   = pend_clear;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Expected results and checking
    // ---------------------------------------------------------------
    seq_out_t pending_outputs[$];
    seq_out_t head_output;
    int       mismatch_count = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                head_output = pending_outputs.pop_front();
                if (m_mode !== head_output.mode)
                    report_mismatch($sformatf("mode got %0d want %0d",
                        m_mode, head_output.mode));
                if (m_host_power !== head_output.host)
                    report_mismatch($sformatf("host_power got %0b want %0b",
                        m_host_power, head_output.host));
                if (m_port1_power !== head_output.port1)
                    report_mismatch($sformatf("port1_power got %0b want %0b",
                        m_port1_power, head_output.port1));
                if (m_port2_power !== head_output.port2)
                    report_mismatch($sformatf("port2_power got %0b want %0b",
                        m_port2_power, head_output.port2));
                if (m_led_effect !== head_output.led)
                    report_mismatch($sformatf("led_effect got %0d want %0d",
                        m_led_effect, head_output.led));
                if (m_display_blanked !== head_output.blank)
                    report_mismatch($sformatf("display_blanked got %0b want %0b",
                        m_display_blanked, head_output.blank));
                if (m_display_wake !== head_output.wake)
                    report_mismatch($sformatf("display_wake got %0b want %0b",
                        m_display_wake, head_output.wake));
                if (m_shutdown_request !== head_output.request)
                    report_mismatch($sformatf("shutdown_request got %0b want %0b",
                        m_shutdown_request, head_output.request));
                if (m_clear_host_flag !== head_output.clear)
                    report_mismatch($sformatf("clear_host_flag got %0b want %0b",
                        m_clear_host_flag, head_output.clear));
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: a rotating stall pattern, plus long hold-offs on request
    // ---------------------------------------------------------------
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    logic [5:0] rx_cycle = '0;
    rx_style_t rx_style = RX_OPEN;

    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            // Start a long hold-off; the sender keeps offering meanwhile.
            hold_served <= hold_requests;
            hold_left   <= RX_HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1'b1;
            if (rx_cycle == '0) rx_style <= rx_style_t'($urandom_range(0, 3));
            case (rx_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_cycle[1:0] == 2'b11);
                default:   m_ready <= ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    int                         burst_left = 0;
    int                         long_left = 0;
    logic [bps_pkg::TIME_W-1:0] wall_ms = '0;
    dir_row_t                   dir_rows [DIR_ROWS];

    // Offer one transaction, hold it until accepted, then queue what it must produce.
    task automatic offer_pass(input bps_pkg::item_t it, input logic typed,
                              input seq_out_t want);
        seq_out_t predicted;
        s_valid          <= 1'b1;
        s_now_ms         <= it.now_ms;
        s_button_clicked <= it.button_clicked;
        s_button_long    <= it.button_long;
        s_link_up        <= it.link_up;
        s_host_shutdown  <= it.host_shutdown;
        s_port1_wanted   <= it.port1_wanted;
        s_port2_wanted   <= it.port2_wanted;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = sequence_pass(it);
        pending_outputs.push_back(typed ? want : predicted);
    endtask

    // Work in bursts: count down the current burst, then drop valid for a random gap.
    task automatic sender_pause();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_outputs.size() != 0) @(posedge aclk);
    endtask

    // Write both timeouts; only called with valid low and nothing pending.
    task automatic set_timeouts(input logic [bps_pkg::TIME_W-1:0] boot_ms,
                                input logic [bps_pkg::TIME_W-1:0] shut_ms);
        cfg_wr_en <= 1'b1;
        cfg_index <= bps_pkg::CFG_BOOT_TIMEOUT;
        cfg_data  <= boot_ms;
        @(posedge aclk);
        boot_limit = boot_ms;
        cfg_index <= bps_pkg::CFG_SHUTDOWN_WAIT;
        cfg_data  <= shut_ms;
        @(posedge aclk);
        shut_limit = shut_ms;
        cfg_wr_en <= 1'b0;
    endtask

    // Build a pass that mostly follows a plausible session, with some noise.
    function automatic bps_pkg::item_t make_pass();
        bps_pkg::item_t it;
        int unsigned    pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // Noise: any timestamp, any flags.
            it.now_ms = $urandom();
            {it.button_clicked, it.button_long, it.link_up, it.host_shutdown,
             it.port1_wanted, it.port2_wanted} = 6'($urandom_range(0, 63));
            wall_ms = it.now_ms;
            return it;
        end

        // Advance the clock; often land right at or just short of a timeout.
        pick = $urandom_range(0, 99);
        if (pick < 60)
            wall_ms = wall_ms + $urandom_range(0, 30);
        else if (pick < 85 && seq_mode == bps_pkg::MODE_BOOT)
            wall_ms = seq_stamp + boot_limit - $urandom_range(0, 1);
        else if (pick < 85 && seq_mode == bps_pkg::MODE_SHUT)
            wall_ms = seq_stamp + shut_limit - $urandom_range(0, 1);
        else if (pick < 92)
            wall_ms = wall_ms + $urandom();
        else
            wall_ms = wall_ms + $urandom_range(0, 3000);
        it.now_ms = wall_ms;

        // Hold the long press for a few passes at a time.
        if (long_left == 0 && $urandom_range(0, 99) < 5) long_left = $urandom_range(1, 4);
        it.button_long = (long_left != 0);
        if (long_left != 0) long_left--;

        it.button_clicked = ($urandom_range(0, 99) < 22);
        case (seq_mode)
            bps_pkg::MODE_BOOT: it.link_up = ($urandom_range(0, 99) < 40);
            bps_pkg::MODE_CONN: it.link_up = ($urandom_range(0, 99) < 92);
            default:            it.link_up = 1'($urandom_range(0, 1));
        endcase
        it.host_shutdown = ($urandom_range(0, 99) < 12);
        it.port1_wanted  = 1'($urandom_range(0, 1));
        it.port2_wanted  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // One phase of random passes under one setting of the timeouts.
    // hold_at starts a long receiver hold-off; drain_at pauses until all results are in.
    task automatic run_phase(input logic [bps_pkg::TIME_W-1:0] boot_ms,
                             input logic [bps_pkg::TIME_W-1:0] shut_ms,
                             input int count, input int hold_at, input int drain_at);
        bps_pkg::item_t it;
        wait_drained();
        set_timeouts(boot_ms, shut_ms);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) begin
                hold_requests <= hold_requests + 1;
                burst_left = 400;
            end
            it = make_pass();
            offer_pass(it, 1'b0, OUT_NONE);
            if (k == drain_at) begin
                s_valid <= 1'b0;
                wait_drained();
            end else begin
                sender_pause();
            end
        end
        s_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        bps_pkg::item_t it;

        // Directed table, reset timeouts (60000 / 10000 ms).
        dir_rows[0]  = '{32'd0,          6'b000000, 1'b1, OUT_OFF_IDLE};    // after reset
        dir_rows[1]  = '{32'd100,        6'b100000, 1'b0, OUT_NONE};        // click: boot
        dir_rows[2]  = '{32'd200,        6'b001010, 1'b0, OUT_NONE};        // link: connected
        dir_rows[3]  = '{32'd300,        6'b001100, 1'b0, OUT_NONE};        // host flag
        dir_rows[4]  = '{32'd10299,      6'b001000, 1'b0, OUT_NONE};        // one short of wait
        dir_rows[5]  = '{32'd10300,      6'b001000, 1'b0, OUT_NONE};        // wait expires
        dir_rows[6]  = '{32'd10400,      6'b100000, 1'b0, OUT_NONE};        // boot again
        dir_rows[7]  = '{32'd70400,      6'b001000, 1'b1, OUT_ERR_ENTRY};   // link and timeout
        dir_rows[8]  = '{32'd70500,      6'b100000, 1'b0, OUT_NONE};        // click leaves error
        dir_rows[9]  = '{32'd70600,      6'b110000, 1'b1, OUT_OFF_CLEARED}; // long hides click
        dir_rows[10] = '{32'd70700,      6'b110000, 1'b0, OUT_NONE};        // long held: click
        dir_rows[11] = '{32'd70800,      6'b001011, 1'b0, OUT_NONE};        // release, connect
        dir_rows[12] = '{32'd70900,      6'b000100, 1'b1, OUT_ERR_ENTRY};   // link lost, flag
        dir_rows[13] = '{32'd71000,      6'b100000, 1'b0, OUT_NONE};
        dir_rows[14] = '{32'd71100,      6'b100000, 1'b0, OUT_NONE};
        dir_rows[15] = '{32'd71200,      6'b001001, 1'b0, OUT_NONE};
        dir_rows[16] = '{32'd71300,      6'b101000, 1'b0, OUT_NONE};        // click: shut down
        dir_rows[17] = '{32'd71400,      6'b010000, 1'b1, OUT_OFF_CLEARED}; // long from shut
        dir_rows[18] = '{32'hFFFF_FFFF,  6'b100000, 1'b0, OUT_NONE};        // boot at top
        dir_rows[19] = '{32'd59999,      6'b000000, 1'b1, OUT_ERR_ENTRY};   // timeout over wrap
        dir_rows[20] = '{32'd0,          6'b010000, 1'b1, OUT_OFF_CLEARED}; // long from error
        dir_rows[21] = '{32'd5,          6'b101111, 1'b0, OUT_NONE};
        dir_rows[22] = '{32'd6,          6'b101111, 1'b0, OUT_NONE};
        dir_rows[23] = '{32'd7,          6'b111111, 1'b1, OUT_OFF_CLEARED}; // long from conn

        // Hold reset, then release it for good.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            it = bps_pkg::item_t'({dir_rows[i].now_ms, dir_rows[i].flags});
            offer_pass(it, dir_rows[i].typed, dir_rows[i].want);
            sender_pause();
        end
        s_valid <= 1'b0;
        wall_ms = 32'd100;

        // Random phases over several timeout settings, extremes included.
        run_phase(32'd40, 32'd25, 250, -1, 120);
        run_phase(32'd0, 32'd0, 150, -1, -1);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150, -1, -1);
        run_phase($urandom_range(1, 200), $urandom_range(1, 200), 250, 100, -1);
        run_phase($urandom(), $urandom(), 150, -1, -1);
        run_phase(bps_pkg::BOOT_TIMEOUT_RESET, bps_pkg::SHUTDOWN_WAIT_RESET, 150, 40, -1);

        // Drain, then let the pipeline idle so that anything stray shows.
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bps_pkg.sv
hdl/bps_step.sv
hdl/board_power_sequencer.sv
sim/board_power_sequencer_tb.sv
